@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file svbv_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted (active-low reset).
`define SVBV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SVBV_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/svbv_pkg.sv @@
// ----------------------------------------------------------------------------
// svbv_pkg
// Shared constants and types of the swept box velocity resolver.
// ----------------------------------------------------------------------------
package svbv_pkg;

    // Depth of the queue between classifier and resolver
    localparam int unsigned QUEUE_DEPTH = 4;
    // Quotient bits of the entry time, one divider stage each
    localparam int unsigned DIV_STEPS   = 16;

    typedef enum logic [2:0] {
        NRM_NONE = 3'd0,
        NRM_PX   = 3'd1,
        NRM_MX   = 3'd2,
        NRM_PY   = 3'd3,
        NRM_MY   = 3'd4
    } t_normal;

    // One classified pair waiting for the divider
    typedef struct packed {
        logic        ovl;
        logic        hit;
        t_normal     code;
        logic [40:0] rem;   // entry numerator times 2^16
        logic [39:0] dvs;   // entry denominator times step time
        logic [23:0] vx;
        logic [23:0] vy;
    } t_qent;

endpackage

@@ rtl/core/svbv_front.sv @@
// ----------------------------------------------------------------------------
// svbv_front
// Accepts box pairs, runs the overlap test and the slab classification, and
// pushes the divider operands into the queue.
// ----------------------------------------------------------------------------
module svbv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [23:0]          i_mover_x,
    input  logic [23:0]          i_mover_y,
    input  logic [22:0]          i_mover_w,
    input  logic [22:0]          i_mover_h,
    input  logic [23:0]          i_vel_x,
    input  logic [23:0]          i_vel_y,
    input  logic [23:0]          i_target_x,
    input  logic [23:0]          i_target_y,
    input  logic [22:0]          i_target_w,
    input  logic [22:0]          i_target_h,
    input  logic [15:0]          i_step_time,
    input  logic                 i_resolve,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output svbv_pkg::t_qent      o_q_data
);

    typedef struct packed {
        logic [25:0] n;     // numerator, signed; +1 or -1 when d is zero
        logic [23:0] d;     // magnitude of velocity, zero means infinite
    } t_tval;

    function automatic logic signed [25:0] sxt(input logic [23:0] v);
        return $signed({{2{v[23]}}, v});
    endfunction

    function automatic logic signed [25:0] zxt(input logic [22:0] v);
        return $signed({3'b000, v});
    endfunction

    function automatic logic [23:0] absv(input logic [23:0] v);
        return v[23] ? 24'(-v) : v;
    endfunction

    function automatic t_tval slab_near(input logic signed [25:0] nn,
                                        input logic signed [25:0] nf,
                                        input logic [23:0] v);
        t_tval t;
        if (v == 24'd0) begin
            t.n = (nn > 26'sd0) ? 26'd1 : 26'(-26'sd1);
            t.d = 24'd0;
        end else if (v[23]) begin
            t.n = 26'(-nf);
            t.d = absv(v);
        end else begin
            t.n = nn;
            t.d = v;
        end
        return t;
    endfunction

    function automatic t_tval slab_far(input logic signed [25:0] nn,
                                       input logic signed [25:0] nf,
                                       input logic [23:0] v);
        t_tval t;
        if (v == 24'd0) begin
            t.n = (nf > 26'sd0) ? 26'd1 : 26'(-26'sd1);
            t.d = 24'd0;
        end else if (v[23]) begin
            t.n = 26'(-nn);
            t.d = absv(v);
        end else begin
            t.n = nf;
            t.d = v;
        end
        return t;
    endfunction

    function automatic logic signed [50:0] xmul(input logic [25:0] n,
                                                input logic [23:0] d);
        return 51'($signed(n)) * 51'($signed({1'b0, d}));
    endfunction

    // Compare two times given the cross products l = a.n*b.d and r = b.n*a.d
    function automatic logic signed [1:0] tcmp(input t_tval a, input t_tval b,
                                               input logic signed [50:0] l,
                                               input logic signed [50:0] r);
        logic signed [1:0] c;
        if (a.d == 24'd0 && b.d == 24'd0) begin
            c = ($signed(a.n) > $signed(b.n)) ? 2'sd1 :
                (($signed(a.n) < $signed(b.n)) ? -2'sd1 : 2'sd0);
        end else if (a.d == 24'd0) begin
            c = ($signed(a.n) > 26'sd0) ? 2'sd1 : -2'sd1;
        end else if (b.d == 24'd0) begin
            c = ($signed(b.n) > 26'sd0) ? -2'sd1 : 2'sd1;
        end else begin
            c = (l > r) ? 2'sd1 : ((l < r) ? -2'sd1 : 2'sd0);
        end
        return c;
    endfunction

    logic en;

    // stage 0: captured input
    logic        r0_valid;
    logic [23:0] r0_mx, r0_my, r0_vx, r0_vy, r0_tx, r0_ty;
    logic [22:0] r0_mw, r0_mh, r0_tw, r0_th;
    logic [15:0] r0_dt;
    logic        r0_res;

    // stage 1: slab times
    logic        r1_valid, r1_ovl, r1_act;
    t_tval       r1_nx, r1_fx, r1_ny, r1_fy;
    logic [23:0] r1_vx, r1_vy;
    logic [15:0] r1_dt;

    // stage 2: cross products
    logic              r2_valid, r2_ovl, r2_act;
    t_tval             r2_nx, r2_fx, r2_ny, r2_fy;
    logic [23:0]       r2_vx, r2_vy;
    logic [15:0]       r2_dt;
    logic signed [50:0] r2_l0, r2_r0, r2_l1, r2_r1, r2_l2, r2_r2, r2_l3, r2_r3;

    // stage 3: near and far picks
    logic              r3_valid, r3_ovl, r3_act;
    logic signed [1:0] r3_cn;
    t_tval             r3_hn, r3_hf;
    logic [23:0]       r3_vx, r3_vy;
    logic [15:0]       r3_dt;

    // stage 4: divider operands
    logic              r4_valid, r4_ovl, r4_act;
    svbv_pkg::t_normal r4_code;
    logic [40:0]       r4_rem;
    logic [39:0]       r4_dvs;
    logic [23:0]       r4_vx, r4_vy;

    logic signed [25:0] nnx, nfx, nny, nfy;
    logic               ovl, go, ok0;
    logic signed [1:0]  c_sx, c_sy, c_n, c_f;
    logic               chk;
    svbv_pkg::t_normal  code;
    logic               hit;

    // Freeze the whole front while the queue is full
    assign en         = !i_q_full;
    assign o_in_ready = en;

    // Overlap test and slab numerators
    always_comb begin
        ovl = (sxt(r0_mx) < sxt(r0_tx) + zxt(r0_tw)) &&
              (sxt(r0_mx) + zxt(r0_mw) > sxt(r0_tx)) &&
              (sxt(r0_my) < sxt(r0_ty) + zxt(r0_th)) &&
              (sxt(r0_my) + zxt(r0_mh) > sxt(r0_ty));
        nnx = sxt(r0_tx) - sxt(r0_mx) - zxt(r0_mw);
        nfx = sxt(r0_tx) + zxt(r0_tw) - sxt(r0_mx);
        nny = sxt(r0_ty) - sxt(r0_my) - zxt(r0_mh);
        nfy = sxt(r0_ty) + zxt(r0_th) - sxt(r0_my);
        go  = ovl && r0_res && (r0_vx != 24'd0 || r0_vy != 24'd0) && r0_dt != 16'd0;
        // zero over zero on either axis
        ok0 = !((r0_vx == 24'd0 && (nnx == 26'sd0 || nfx == 26'sd0)) ||
                (r0_vy == 24'd0 && (nny == 26'sd0 || nfy == 26'sd0)));
    end

    // Time comparisons
    always_comb begin
        c_sx = tcmp(r2_nx, r2_fy, r2_l0, r2_r0);
        c_sy = tcmp(r2_ny, r2_fx, r2_l1, r2_r1);
        c_n  = tcmp(r2_nx, r2_ny, r2_l2, r2_r2);
        c_f  = tcmp(r2_fx, r2_fy, r2_l3, r2_r3);
    end

    // Entry checks and hit normal
    always_comb begin
        chk = r3_hf.n[25] || (r3_hn.d == 24'd0) || r3_hn.n[25];
        if (r3_cn > 2'sd0) begin
            code = r3_vx[23] ? svbv_pkg::NRM_PX : svbv_pkg::NRM_MX;
        end else if (r3_cn < 2'sd0) begin
            code = r3_vy[23] ? svbv_pkg::NRM_PY : svbv_pkg::NRM_MY;
        end else begin
            code = svbv_pkg::NRM_NONE;
        end
    end

    // Reject entry times of one or more and build the queue entry
    always_comb begin
        hit               = r4_act && (r4_rem < {1'b0, r4_dvs});
        o_q_push          = r4_valid && en;
        o_q_data.ovl      = r4_ovl;
        o_q_data.hit      = hit;
        o_q_data.code     = hit ? r4_code : svbv_pkg::NRM_NONE;
        o_q_data.rem      = r4_rem;
        o_q_data.dvs      = r4_dvs;
        o_q_data.vx       = r4_vx;
        o_q_data.vy       = r4_vy;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_in_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_mx  <= i_mover_x;
            r0_my  <= i_mover_y;
            r0_mw  <= i_mover_w;
            r0_mh  <= i_mover_h;
            r0_vx  <= i_vel_x;
            r0_vy  <= i_vel_y;
            r0_tx  <= i_target_x;
            r0_ty  <= i_target_y;
            r0_tw  <= i_target_w;
            r0_th  <= i_target_h;
            r0_dt  <= i_step_time;
            r0_res <= i_resolve;

            r1_ovl <= ovl;
            r1_act <= go && ok0;
            r1_nx  <= slab_near(nnx, nfx, r0_vx);
            r1_fx  <= slab_far(nnx, nfx, r0_vx);
            r1_ny  <= slab_near(nny, nfy, r0_vy);
            r1_fy  <= slab_far(nny, nfy, r0_vy);
            r1_vx  <= r0_vx;
            r1_vy  <= r0_vy;
            r1_dt  <= r0_dt;

            r2_ovl <= r1_ovl;
            r2_act <= r1_act;
            r2_nx  <= r1_nx;
            r2_fx  <= r1_fx;
            r2_ny  <= r1_ny;
            r2_fy  <= r1_fy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_dt  <= r1_dt;
            r2_l0  <= xmul(r1_nx.n, r1_fy.d);
            r2_r0  <= xmul(r1_fy.n, r1_nx.d);
            r2_l1  <= xmul(r1_ny.n, r1_fx.d);
            r2_r1  <= xmul(r1_fx.n, r1_ny.d);
            r2_l2  <= xmul(r1_nx.n, r1_ny.d);
            r2_r2  <= xmul(r1_ny.n, r1_nx.d);
            r2_l3  <= xmul(r1_fx.n, r1_fy.d);
            r2_r3  <= xmul(r1_fy.n, r1_fx.d);

            r3_ovl <= r2_ovl;
            r3_act <= r2_act && !(c_sx > 2'sd0) && !(c_sy > 2'sd0);
            r3_cn  <= c_n;
            r3_hn  <= (c_n >= 2'sd0) ? r2_nx : r2_ny;
            r3_hf  <= (c_f <= 2'sd0) ? r2_fx : r2_fy;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
            r3_dt  <= r2_dt;

            r4_ovl  <= r3_ovl;
            r4_act  <= r3_act && !chk;
            r4_code <= code;
            r4_rem  <= {1'b0, r3_hn.n[23:0], 16'd0};
            r4_dvs  <= 40'(r3_hn.d) * 40'(r3_dt);
            r4_vx   <= r3_vx;
            r4_vy   <= r3_vy;
        end
    end

endmodule

@@ rtl/core/svbv_queue.sv @@
// ----------------------------------------------------------------------------
// svbv_queue
// Small FIFO that decouples the classifier from the resolver.
// ----------------------------------------------------------------------------
module svbv_queue #(
    parameter int unsigned DEPTH = svbv_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  svbv_pkg::t_qent i_data,
    output logic            o_full,
    input  logic            i_pop,
    output svbv_pkg::t_qent o_data,
    output logic            o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    svbv_pkg::t_qent r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/svbv_back.sv @@
// ----------------------------------------------------------------------------
// svbv_back
// Pipelined entry-time divider and velocity correction with output register.
// ----------------------------------------------------------------------------
module svbv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svbv_pkg::t_qent i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_overlap,
    output logic            o_swept_hit,
    output logic [15:0]     o_entry_time,
    output logic [2:0]      o_normal_code,
    output logic [23:0]     o_new_vel_x,
    output logic [23:0]     o_new_vel_y
);

    localparam int unsigned NST = svbv_pkg::DIV_STEPS;
    localparam logic signed [25:0] VMAX = 26'sd8388607;
    localparam logic signed [25:0] VMIN = -26'sd8388608;

    typedef struct packed {
        svbv_pkg::t_qent e;
        logic [15:0]     q;
    } t_dst;

    function automatic t_dst dstep(input t_dst s);
        t_dst        o;
        logic [40:0] r2;
        o  = s;
        r2 = {s.e.rem[39:0], 1'b0};
        if (r2 >= {1'b0, s.e.dvs}) begin
            o.e.rem = r2 - {1'b0, s.e.dvs};
            o.q     = {s.q[14:0], 1'b1};
        end else begin
            o.e.rem = r2;
            o.q     = {s.q[14:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [23:0] sat(input logic signed [25:0] s);
        logic [23:0] v;
        if (s > VMAX) begin
            v = 24'h7FFFFF;
        end else if (s < VMIN) begin
            v = 24'h800000;
        end else begin
            v = s[23:0];
        end
        return v;
    endfunction

    logic en;
    logic r_dv [NST+1];
    t_dst r_st [NST+1];

    logic            r_m_valid;
    svbv_pkg::t_qent r_m_e;
    logic [15:0]     r_m_q;
    logic [40:0]     r_m_prod;

    logic            r_out_valid;
    logic            r_ovl, r_hit;
    logic [15:0]     r_ct;
    logic [2:0]      r_code;
    logic [23:0]     r_nvx, r_nvy;

    logic [23:0]        m_v, m_av;
    logic [23:0]        corr;
    logic signed [25:0] s_plus_x, s_minus_x, s_plus_y, s_minus_y;

    // Stall everything while a finished result waits
    assign en      = !r_out_valid || i_out_ready;
    assign o_q_pop = en && !i_q_empty;

    always_comb begin
        m_v  = (r_st[NST].e.code == svbv_pkg::NRM_PX ||
                r_st[NST].e.code == svbv_pkg::NRM_MX) ? r_st[NST].e.vx : r_st[NST].e.vy;
        m_av = m_v[23] ? 24'(-m_v) : m_v;
    end

    // Correction terms
    always_comb begin
        corr      = r_m_prod[39:16];
        s_plus_x  = $signed({{2{r_m_e.vx[23]}}, r_m_e.vx}) + $signed({2'b00, corr});
        s_minus_x = $signed({{2{r_m_e.vx[23]}}, r_m_e.vx}) - $signed({2'b00, corr});
        s_plus_y  = $signed({{2{r_m_e.vy[23]}}, r_m_e.vy}) + $signed({2'b00, corr});
        s_minus_y = $signed({{2{r_m_e.vy[23]}}, r_m_e.vy}) - $signed({2'b00, corr});
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_dv[0] <= !i_q_empty;
            for (int k = 1; k <= NST; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_m_valid   <= r_dv[NST];
            r_out_valid <= r_m_valid;
        end
    end

    // Divide one quotient bit per stage, then correct the hit axis
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0].e <= i_q_data;
            r_st[0].q <= 16'd0;
            for (int k = 1; k <= NST; k++) begin
                r_st[k] <= dstep(r_st[k-1]);
            end
            r_m_e    <= r_st[NST].e;
            r_m_q    <= r_st[NST].q;
            r_m_prod <= 41'(m_av) * 41'(17'h10000 - {1'b0, r_st[NST].q});

            r_ovl  <= r_m_e.ovl;
            r_hit  <= r_m_e.hit;
            r_ct   <= r_m_e.hit ? r_m_q : 16'd0;
            r_code <= r_m_e.code;
            unique case (r_m_e.code)
                svbv_pkg::NRM_PX: begin
                    r_nvx <= sat(s_plus_x);
                    r_nvy <= r_m_e.vy;
                end
                svbv_pkg::NRM_MX: begin
                    r_nvx <= sat(s_minus_x);
                    r_nvy <= r_m_e.vy;
                end
                svbv_pkg::NRM_PY: begin
                    r_nvx <= r_m_e.vx;
                    r_nvy <= sat(s_plus_y);
                end
                svbv_pkg::NRM_MY: begin
                    r_nvx <= r_m_e.vx;
                    r_nvy <= sat(s_minus_y);
                end
                default: begin
                    r_nvx <= r_m_e.vx;
                    r_nvy <= r_m_e.vy;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_overlap      = r_ovl;
    assign o_swept_hit    = r_hit;
    assign o_entry_time   = r_ct;
    assign o_normal_code  = r_code;
    assign o_new_vel_x    = r_nvx;
    assign o_new_vel_y    = r_nvy;

endmodule

@@ rtl/core/swept_box_box_velocity_resolve.sv @@
// Throughput: one box pair per cycle while the queue has room, through the
// 16-stage pipelined divider.
// Output back-pressure fills the 4-entry queue before o_in_ready drops.
// Reset (synchronous, active low) clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
// swept_box_box_velocity_resolve
// Swept box-versus-box test with velocity correction along the hit normal.
// ----------------------------------------------------------------------------
module swept_box_box_velocity_resolve #(
    parameter int unsigned QUEUE_DEPTH = svbv_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_mover_x,
    input  logic [23:0] i_mover_y,
    input  logic [22:0] i_mover_w,
    input  logic [22:0] i_mover_h,
    input  logic [23:0] i_vel_x,
    input  logic [23:0] i_vel_y,
    input  logic [23:0] i_target_x,
    input  logic [23:0] i_target_y,
    input  logic [22:0] i_target_w,
    input  logic [22:0] i_target_h,
    input  logic [15:0] i_step_time,
    input  logic        i_resolve,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_overlap,
    output logic        o_swept_hit,
    output logic [15:0] o_entry_time,
    output logic [2:0]  o_normal_code,
    output logic [23:0] o_new_vel_x,
    output logic [23:0] o_new_vel_y
);

    logic            q_push, q_full, q_pop, q_empty;
    svbv_pkg::t_qent q_wdata, q_rdata;

    // Classify incoming pairs
    svbv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mover_x   (i_mover_x),
        .i_mover_y   (i_mover_y),
        .i_mover_w   (i_mover_w),
        .i_mover_h   (i_mover_h),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_target_w  (i_target_w),
        .i_target_h  (i_target_h),
        .i_step_time (i_step_time),
        .i_resolve   (i_resolve),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // Buffer classified transactions
    svbv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Divide and correct
    svbv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_rdata),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_overlap      (o_overlap),
        .o_swept_hit    (o_swept_hit),
        .o_entry_time   (o_entry_time),
        .o_normal_code  (o_normal_code),
        .o_new_vel_x    (o_new_vel_x),
        .o_new_vel_y    (o_new_vel_y)
    );

endmodule

@@ rtl/core/svbv_checker.sv @@
// ----------------------------------------------------------------------------
// svbv_checker
// Port-level checks of the swept box velocity resolver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svbv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [23:0] i_mover_x,
    input logic [23:0] i_mover_y,
    input logic [22:0] i_mover_w,
    input logic [22:0] i_mover_h,
    input logic [23:0] i_vel_x,
    input logic [23:0] i_vel_y,
    input logic [23:0] i_target_x,
    input logic [23:0] i_target_y,
    input logic [22:0] i_target_w,
    input logic [22:0] i_target_h,
    input logic [15:0] i_step_time,
    input logic        i_resolve,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_overlap,
    input logic        o_swept_hit,
    input logic [15:0] o_entry_time,
    input logic [2:0]  o_normal_code,
    input logic [23:0] o_new_vel_x,
    input logic [23:0] o_new_vel_y
);

    // Reset empties the output stage
    `SVBV_ASSERT_RST(a_rst_clears, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")

    // Hold a stalled transaction
    `SVBV_ASSERT(a_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "valid dropped")
    `SVBV_ASSERT(a_data_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_entry_time) && $stable(o_new_vel_x) && $stable(o_new_vel_y), "payload changed")

    // A sweep only runs on overlapping boxes
    `SVBV_ASSERT(a_hit_needs_ovl, i_clk, i_rst_n, o_out_valid && !o_overlap |-> !o_swept_hit, "hit without overlap")

    // A miss reports no time and no normal
    `SVBV_ASSERT(a_miss_clean, i_clk, i_rst_n, o_out_valid && !o_swept_hit |-> (o_entry_time == 16'd0) && (o_normal_code == svbv_pkg::NRM_NONE), "miss not clean")

endmodule

bind swept_box_box_velocity_resolve svbv_checker u_svbv_checker (.*);

@@ test/tb_swept_box_box_velocity_resolve.sv @@
// ----------------------------------------------------------------------------
// tb_swept_box_box_velocity_resolve
// Streams box pairs through the swept resolver with bursty input, stalling
// output and one long output hold-off. Each transaction is checked field by
// field against a fixed-point slab-method predictor kept in this file.
// ----------------------------------------------------------------------------
module tb_swept_box_box_velocity_resolve;

    localparam int N_RANDOM = 1450;

    typedef struct {
        logic [23:0] mx, my;
        logic [22:0] mw, mh;
        logic [23:0] vx, vy;
        logic [23:0] tx, ty;
        logic [22:0] tw, th;
        logic [15:0] dt;
        logic        res;
    } t_pair;

    typedef struct packed {
        logic              ovl;
        logic              hit;
        logic [15:0]       tq;
        svbv_pkg::t_normal code;
        logic [23:0]       nvx;
        logic [23:0]       nvy;
    } t_outcome;

    // Directed row: pair, a flag saying whether the typed outcome is used
    typedef struct {
        t_pair    p;
        bit       typed;
        t_outcome o;
    } t_row;

    // A slab time as a fraction; den == 0 means signed infinity
    typedef struct {
        longint num;
        longint den;
    } t_frac;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_pair       drv;
    logic        out_valid;
    logic        out_ready;
    logic        ovl_o, hit_o;
    logic [15:0] tq_o;
    logic [2:0]  code_o;
    logic [23:0] nvx_o, nvy_o;

    t_outcome    expected_q[$];
    int          n_errors;
    int          hold_cycles;
    bit          stim_done;

    swept_box_box_velocity_resolve DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_mover_x(drv.mx), .i_mover_y(drv.my), .i_mover_w(drv.mw), .i_mover_h(drv.mh),
        .i_vel_x(drv.vx), .i_vel_y(drv.vy),
        .i_target_x(drv.tx), .i_target_y(drv.ty), .i_target_w(drv.tw), .i_target_h(drv.th),
        .i_step_time(drv.dt), .i_resolve(drv.res),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_overlap(ovl_o), .o_swept_hit(hit_o), .o_entry_time(tq_o),
        .o_normal_code(code_o), .o_new_vel_x(nvx_o), .o_new_vel_y(nvy_o)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Compare two slab times; infinities order by sign
    function automatic int frac_cmp(t_frac a, t_frac b);
        longint l, r;
        if (a.den == 0 && b.den == 0) return (a.num > b.num) - (a.num < b.num);
        if (a.den == 0) return a.num > 0 ? 1 : -1;
        if (b.den == 0) return b.num > 0 ? -1 : 1;
        l = a.num * b.den;
        r = b.num * a.den;
        return (l > r) - (l < r);
    endfunction

    function automatic void slab_times(longint nn, longint nf, longint v,
                                       output t_frac ent, output t_frac ext);
        if (v > 0) begin
            ent = '{nn, v};
            ext = '{nf, v};
        end else if (v < 0) begin
            ent = '{-nf, -v};
            ext = '{-nn, -v};
        end else begin
            ent = '{(nn > 0) ? 1 : -1, 0};
            ext = '{(nf > 0) ? 1 : -1, 0};
        end
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // Velocity pull-back: |v| * (1 - t), floor
    function automatic longint pullback(longint v, longint tq);
        longint a;
        a = (v < 0) ? -v : v;
        return (a * (65536 - tq)) >>> 16;
    endfunction

    function automatic t_outcome resolve_pair(t_pair p);
        t_outcome o;
        longint mx, my, mw, mh, vx, vy, tx, ty, tw, th, dt;
        longint nnx, nfx, nny, nfy, nvx, nvy, tq;
        t_frac  ex, fx, ey, fy, hn, hf;
        bit     ok;
        int     c;
        mx = $signed(p.mx); my = $signed(p.my);
        vx = $signed(p.vx); vy = $signed(p.vy);
        tx = $signed(p.tx); ty = $signed(p.ty);
        mw = p.mw; mh = p.mh; tw = p.tw; th = p.th; dt = p.dt;
        nvx = vx; nvy = vy; tq = 0;
        o.ovl = (mx < tx + tw) && (mx + mw > tx) && (my < ty + th) && (my + mh > ty);
        o.hit = 1'b0;
        o.code = svbv_pkg::NRM_NONE;
        if (o.ovl && p.res && (vx != 0 || vy != 0) && dt != 0) begin
            nnx = tx - mx - mw; nfx = tx + tw - mx;
            nny = ty - my - mh; nfy = ty + th - my;
            // zero over zero on either axis gives no hit
            ok = !((vx == 0 && (nnx == 0 || nfx == 0)) ||
                   (vy == 0 && (nny == 0 || nfy == 0)));
            if (ok) begin
                slab_times(nnx, nfx, vx, ex, fx);
                slab_times(nny, nfy, vy, ey, fy);
                if (frac_cmp(ex, fy) > 0 || frac_cmp(ey, fx) > 0) ok = 0;
            end
            if (ok) begin
                hn = (frac_cmp(ex, ey) >= 0) ? ex : ey;
                hf = (frac_cmp(fx, fy) <= 0) ? fx : fy;
                if (hf.num < 0 || hn.den == 0 || hn.num < 0 || hn.num * 65536 >= hn.den * dt)
                    ok = 0;
            end
            if (ok) begin
                c = frac_cmp(ex, ey);
                o.hit = 1'b1;
                tq = (hn.num <<< 32) / (hn.den * dt);
                if (tq > 65535) tq = 65535;
                // tied entry times leave the normal at none
                if (c > 0) o.code = (vx < 0) ? svbv_pkg::NRM_PX : svbv_pkg::NRM_MX;
                else if (c < 0) o.code = (vy < 0) ? svbv_pkg::NRM_PY : svbv_pkg::NRM_MY;
                case (o.code)
                    svbv_pkg::NRM_PX: nvx = clamp24(vx + pullback(vx, tq));
                    svbv_pkg::NRM_MX: nvx = clamp24(vx - pullback(vx, tq));
                    svbv_pkg::NRM_PY: nvy = clamp24(vy + pullback(vy, tq));
                    svbv_pkg::NRM_MY: nvy = clamp24(vy - pullback(vy, tq));
                    default: ;
                endcase
            end
        end
        o.tq = tq[15:0];
        o.nvx = nvx[23:0];
        o.nvy = nvy[23:0];
        return o;
    endfunction

    function automatic t_pair mk(int mx, int my, int mw, int mh, int vx, int vy,
                                 int tx, int ty, int tw, int th, int dt, bit res);
        t_pair p;
        p.mx = 24'(mx); p.my = 24'(my); p.mw = 23'(mw); p.mh = 23'(mh);
        p.vx = 24'(vx); p.vy = 24'(vy);
        p.tx = 24'(tx); p.ty = 24'(ty); p.tw = 23'(tw); p.th = 23'(th);
        p.dt = 16'(dt); p.res = res;
        return p;
    endfunction

    // Random pair: mostly near-contact geometry with small sizes, some noise
    function automatic t_pair random_pair();
        t_pair p;
        int    sel;
        sel = int'($urandom_range(0, 9));
        if (sel < 7) begin
            p.tx = 24'($urandom_range(0, 4096) - 2048);
            p.ty = 24'($urandom_range(0, 4096) - 2048);
            p.tw = 23'($urandom_range(0, 2048));
            p.th = 23'($urandom_range(0, 2048));
            p.mw = 23'($urandom_range(0, 2048));
            p.mh = 23'($urandom_range(0, 2048));
            p.mx = p.tx + 24'($urandom_range(0, 4096)) - 24'd2048;
            p.my = p.ty + 24'($urandom_range(0, 4096)) - 24'd2048;
            case ($urandom_range(0, 3))
                0: p.vx = 24'd0;
                1: p.vx = 24'($urandom);
                default: p.vx = 24'($urandom_range(0, 8192) - 4096);
            endcase
            case ($urandom_range(0, 3))
                0: p.vy = 24'd0;
                1: p.vy = 24'($urandom);
                default: p.vy = 24'($urandom_range(0, 8192) - 4096);
            endcase
            p.dt = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
            p.res = ($urandom_range(0, 7) != 0);
        end else begin
            p.mx = 24'($urandom); p.my = 24'($urandom);
            p.mw = 23'($urandom); p.mh = 23'($urandom);
            p.vx = 24'($urandom); p.vy = 24'($urandom);
            p.tx = 24'($urandom); p.ty = 24'($urandom);
            p.tw = 23'($urandom); p.th = 23'($urandom);
            p.dt = 16'($urandom); p.res = 1'($urandom);
        end
        return p;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Offer one transaction after a gap given by the caller, and hold it until accepted
    task automatic send_pair(t_pair p, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        drv <= p;
        in_valid <= 1'b1;
        expected_q.push_back(resolve_pair(p));
        do @(posedge clk); while (!in_ready);
    endtask

    // Stimulus
    initial begin
        t_row     rows[$];
        t_outcome none;
        int       burst;
        in_valid = 1'b0;
        drv = '{default: '0};
        rst_n = 1'b0;
        stim_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        none = '{0, 0, 0, svbv_pkg::NRM_NONE, 0, 0};
        // all zero: no overlap, velocity passes through
        rows.push_back('{mk(0,0,0,0,0,0,0,0,0,0,0,0), 1, none});
        // extremes of every field, no overlap
        rows.push_back('{mk(-8388608,-8388608,8388607,8388607,-8388608,8388607,
                            8388607,8388607,8388607,8388607,65535,1), 0, none});
        rows.push_back('{mk(8388607,8388607,0,0,8388607,-8388608,
                            -8388608,-8388608,0,0,65535,1), 1,
                         '{0,0,0,svbv_pkg::NRM_NONE,24'h7FFFFF,24'h800000}});
        // overlap but resolve clear
        rows.push_back('{mk(0,0,256,256,256,0,128,0,256,256,65535,0), 1,
                         '{1,0,0,svbv_pkg::NRM_NONE,24'd256,24'd0}});
        // overlap, zero velocity
        rows.push_back('{mk(0,0,256,256,0,0,128,0,256,256,65535,1), 1,
                         '{1,0,0,svbv_pkg::NRM_NONE,24'd0,24'd0}});
        // overlap, zero step
        rows.push_back('{mk(0,0,256,256,256,0,128,0,256,256,0,1), 1,
                         '{1,0,0,svbv_pkg::NRM_NONE,24'd256,24'd0}});
        // touching edges: no overlap
        rows.push_back('{mk(0,0,256,256,256,0,256,0,256,256,65535,1), 1,
                         '{0,0,0,svbv_pkg::NRM_NONE,24'd256,24'd0}});
        // zero over zero on y axis
        rows.push_back('{mk(0,0,256,256,256,0,128,256,256,256,65535,1), 0, none});
        // overlapping cases reaching the slab logic, each sign of velocity
        rows.push_back('{mk(0,0,256,256,512,0,128,0,256,256,65535,1), 0, none});
        rows.push_back('{mk(0,0,256,256,-512,0,-128,0,256,256,65535,1), 0, none});
        rows.push_back('{mk(0,0,256,256,0,512,0,128,256,256,65535,1), 0, none});
        rows.push_back('{mk(0,0,256,256,0,-512,0,-128,256,256,65535,1), 0, none});
        // tied entry times on a diagonal
        rows.push_back('{mk(0,0,256,256,256,256,100,100,256,256,65535,1), 0, none});
        // velocity extremes, with overlap in all rows but the last
        rows.push_back('{mk(0,0,512,512,8388607,-8388608,100,100,512,512,1,1), 0, none});
        rows.push_back('{mk(0,0,512,512,-8388608,8388607,100,100,512,512,65535,1), 0, none});
        rows.push_back('{mk(-8388608,-8388608,8388607,8388607,-8388608,-8388608,
                            -8388608,-8388608,8388607,8388607,65535,1), 0, none});
        rows.push_back('{mk(-100,-100,8388607,8388607,8388607,8388607,
                            8388607,8388607,8388607,8388607,65535,1), 0, none});

        foreach (rows[i]) begin
            if (rows[i].typed && resolve_pair(rows[i].p) !== rows[i].o)
                report("directed row predictor", i, 0);
            send_pair(rows[i].p, $urandom_range(0, 2));
        end

        // Random bursts with gaps
        burst = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                send_pair(random_pair(), $urandom_range(0, 6));
            end else begin
                send_pair(random_pair(), 0);
            end
            burst--;
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, stretches with none, and one long hold-off
    initial begin
        int mode;
        out_ready = 1'b0;
        hold_cycles = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            hold_cycles++;
            mode = (hold_cycles / 200) % 3;
            if (hold_cycles > 400 && hold_cycles <= 460)
                out_ready <= 1'b0;
            else if (mode == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk) begin
        t_outcome w;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = expected_q.pop_front();
                if (ovl_o !== w.ovl) report("overlap", 32'(ovl_o), 32'(w.ovl));
                if (hit_o !== w.hit) report("swept_hit", 32'(hit_o), 32'(w.hit));
                if (tq_o !== w.tq) report("entry_time", 32'(tq_o), 32'(w.tq));
                if (code_o !== w.code) report("normal_code", 32'(code_o), 32'(w.code));
                if (nvx_o !== w.nvx) report("new_vel_x", 32'(nvx_o), 32'(w.nvx));
                if (nvy_o !== w.nvy) report("new_vel_y", 32'(nvy_o), 32'(w.nvy));
            end
        end
    end

    // Drain, settle, then give the verdict
    initial begin
        n_errors = 0;
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
